// File: rtl/core/brsc_pkg.sv
// Package: payload types, register indexes and float helper functions for the residual kernel.
package brsc_pkg;

	typedef struct packed {
		logic [15:0] a_val;
		logic [15:0] b_val;
		logic [15:0] pre_val;
		logic        last_in;
	} item_t;

	typedef struct packed {
		logic [15:0] result_val;
		logic        last_out;
	} result_t;

	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_PRE = 8'd1;

	localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
	localparam logic [31:0] F32_DEF_NAN = 32'hFFC0_0000;
	localparam logic [31:0] F32_QUIET   = 32'h0040_0000;

	function automatic logic [31:0] bf16_widen(input logic [15:0] h);
		return {h, 16'h0000};
	endfunction

	function automatic logic [15:0] bf16_round(input logic [31:0] u);
		logic [31:0] r;
		r = u + 32'h0000_7FFF + {31'b0, u[16]};
		if (&u[30:23] && |u[22:0])
			return u[31:16] | 16'h0040;
		return r[31:16];
	endfunction

	function automatic logic f32_is_nan(input logic [31:0] u);
		return (&u[30:23]) && (|u[22:0]);
	endfunction

	function automatic logic f32_is_inf(input logic [31:0] u);
		return (&u[30:23]) && !(|u[22:0]);
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic       f;
		n = 5'd27;
		f = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!f && v[i]) begin
				n = 5'(26 - i);
				f = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       f;
		n = 6'd48;
		f = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!f && v[i]) begin
				n = 6'(47 - i);
				f = 1'b1;
			end
		end
		return n;
	endfunction

	// e >= 1; e of 1 with a clear hidden bit packs as subnormal
	function automatic logic [31:0] f32_round_pack(input logic sgn, input logic [9:0] e,
			input logic [23:0] m, input logic g, input logic st);
		logic        inc;
		logic [24:0] mr;
		logic [32:0] v;
		inc = g & (st | m[0]);
		mr  = {1'b0, m} + {24'b0, inc};
		v   = {e - 10'd1, 23'b0} + {8'b0, mr};
		if (v[32:23] >= 10'd255)
			return {sgn, 8'hFF, 23'b0};
		return {sgn, v[30:0]};
	endfunction

endpackage

// File: rtl/core/brsc_fadd.sv
// Three-stage single precision adder: align, add, normalize and round.
module brsc_fadd import brsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic        out_vld,
	output logic [31:0] sum
);

	logic        vld_s1, vld_s2;
	logic        spec_s1, spec_s2;
	logic [31:0] spec_val_s1, spec_val_s2;
	logic        sgn_s1, sgn_s2;
	logic        zsgn_s1, zsgn_s2;
	logic        sub_s1;
	logic [7:0]  exp_s1, exp_s2;
	logic [26:0] mx_s1, my_s1;
	logic [27:0] sum_s2;

	logic        spec_c;
	logic [31:0] spec_val_c;
	logic [31:0] big_c, sml_c;
	logic [7:0]  eb_c, es_c, d_c;
	logic [26:0] ys_c, al_c;
	logic        swap_c;

	always_comb begin
		spec_c     = 1'b1;
		spec_val_c = 32'b0;
		if (f32_is_nan(op_a))
			spec_val_c = op_a | F32_QUIET;
		else if (f32_is_nan(op_b))
			spec_val_c = op_b | F32_QUIET;
		else if (f32_is_inf(op_a) && f32_is_inf(op_b) && (op_a[31] != op_b[31]))
			spec_val_c = F32_DEF_NAN;
		else if (f32_is_inf(op_a))
			spec_val_c = op_a;
		else if (f32_is_inf(op_b))
			spec_val_c = op_b;
		else
			spec_c = 1'b0;
		swap_c = op_b[30:0] > op_a[30:0];
		big_c  = swap_c ? op_b : op_a;
		sml_c  = swap_c ? op_a : op_b;
		eb_c   = (big_c[30:23] == 8'd0) ? 8'd1 : big_c[30:23];
		es_c   = (sml_c[30:23] == 8'd0) ? 8'd1 : sml_c[30:23];
		d_c    = eb_c - es_c;
		ys_c   = {(sml_c[30:23] != 8'd0), sml_c[22:0], 3'b000};
		if (d_c >= 8'd27)
			al_c = {26'b0, |ys_c};
		else
			al_c = (ys_c >> d_c) | {26'b0, |(ys_c & ~({27{1'b1}} << d_c))};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		spec_s1     <= spec_c;
		spec_val_s1 <= spec_val_c;
		sgn_s1      <= big_c[31];
		zsgn_s1     <= op_a[31] & op_b[31];
		sub_s1      <= big_c[31] ^ sml_c[31];
		exp_s1      <= eb_c;
		mx_s1       <= {(big_c[30:23] != 8'd0), big_c[22:0], 3'b000};
		my_s1       <= al_c;
	end

	always_ff @(posedge clk) begin
		spec_s2     <= spec_s1;
		spec_val_s2 <= spec_val_s1;
		sgn_s2      <= sgn_s1;
		zsgn_s2     <= zsgn_s1;
		exp_s2      <= exp_s1;
		sum_s2      <= sub_s1 ? ({1'b0, mx_s1} - {1'b0, my_s1})
		                      : ({1'b0, mx_s1} + {1'b0, my_s1});
	end

	logic [4:0]  lz_c;
	logic [7:0]  sh_c;
	logic [26:0] m27_c;
	logic [9:0]  e_c;
	logic [31:0] res_c;

	always_comb begin
		lz_c  = lzc27(sum_s2[26:0]);
		sh_c  = ({3'b0, lz_c} > (exp_s2 - 8'd1)) ? (exp_s2 - 8'd1) : {3'b0, lz_c};
		m27_c = sum_s2[26:0] << sh_c;
		e_c   = {2'b0, exp_s2} - {2'b0, sh_c};
		if (sum_s2[27]) begin
			m27_c = {sum_s2[27:2], sum_s2[1] | sum_s2[0]};
			e_c   = {2'b0, exp_s2} + 10'd1;
		end
		res_c = f32_round_pack(sgn_s2, e_c, m27_c[26:3], m27_c[2], |m27_c[1:0]);
		if (sum_s2 == 28'd0)
			res_c = {zsgn_s2, 31'b0};
		if (spec_s2)
			res_c = spec_val_s2;
	end

	always_ff @(posedge clk) begin
		sum <= res_c;
	end

endmodule

// File: rtl/core/brsc_fmul.sv
// Three-stage single precision multiplier: product, normalize, denormalize and round.
module brsc_fmul import brsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic        out_vld,
	output logic [31:0] prod
);

	logic        vld_s1, vld_s2;
	logic        spec_s1, spec_s2;
	logic [31:0] spec_val_s1, spec_val_s2;
	logic        sgn_s1, sgn_s2;
	logic [47:0] p_s1, pl_s2;
	logic signed [10:0] e_s1, e_s2;

	logic        spec_c;
	logic [31:0] spec_val_c;
	logic        sgn_c;
	logic        za_c, zb_c;
	logic [7:0]  ea_c, eb_c;

	always_comb begin
		sgn_c      = op_a[31] ^ op_b[31];
		za_c       = op_a[30:0] == 31'd0;
		zb_c       = op_b[30:0] == 31'd0;
		spec_c     = 1'b1;
		spec_val_c = 32'b0;
		if (f32_is_nan(op_a))
			spec_val_c = op_a | F32_QUIET;
		else if (f32_is_nan(op_b))
			spec_val_c = op_b | F32_QUIET;
		else if ((f32_is_inf(op_a) && zb_c) || (za_c && f32_is_inf(op_b)))
			spec_val_c = F32_DEF_NAN;
		else if (f32_is_inf(op_a) || f32_is_inf(op_b))
			spec_val_c = {sgn_c, 8'hFF, 23'b0};
		else if (za_c || zb_c)
			spec_val_c = {sgn_c, 31'b0};
		else
			spec_c = 1'b0;
		ea_c = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
		eb_c = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		spec_s1     <= spec_c;
		spec_val_s1 <= spec_val_c;
		sgn_s1      <= sgn_c;
		p_s1        <= {(op_a[30:23] != 8'd0), op_a[22:0]} * {(op_b[30:23] != 8'd0), op_b[22:0]};
		e_s1        <= $signed({3'b0, ea_c}) + $signed({3'b0, eb_c}) - 11'sd126;
	end

	logic [5:0] lz_c;

	always_comb begin
		lz_c = lzc48(p_s1);
	end

	always_ff @(posedge clk) begin
		spec_s2     <= spec_s1;
		spec_val_s2 <= spec_val_s1;
		sgn_s2      <= sgn_s1;
		pl_s2       <= p_s1 << lz_c;
		e_s2        <= e_s1 - $signed({5'b0, lz_c});
	end

	logic signed [10:0] rs_c;
	logic [47:0] m_c;
	logic        st_c;
	logic [9:0]  ef_c;
	logic [31:0] res_c;

	always_comb begin
		rs_c = 11'sd1 - e_s2;
		m_c  = pl_s2;
		st_c = 1'b0;
		ef_c = 10'd1;
		if (e_s2 >= 11'sd255) begin
			ef_c = 10'd255;
		end else if (e_s2 >= 11'sd1) begin
			ef_c = e_s2[9:0];
		end else if (rs_c >= 11'sd50) begin
			m_c  = 48'd0;
			st_c = |pl_s2;
		end else begin
			m_c  = pl_s2 >> rs_c[5:0];
			st_c = |(pl_s2 & ~({48{1'b1}} << rs_c[5:0]));
		end
		res_c = f32_round_pack(sgn_s2, ef_c, m_c[47:24], m_c[23], (|m_c[22:0]) | st_c);
		if (spec_s2)
			res_c = spec_val_s2;
	end

	always_ff @(posedge clk) begin
		prod <= res_c;
	end

endmodule

// File: rtl/core/bf16_residual_add_scale.sv
// Top level: bf16 residual add, optional pre operand add, scale and bf16 rounding.
// Takes one item per clock with no gaps; busy never rises. Each result passes through
// three three-stage float units in a row (sum adder, pre adder, scale multiplier),
// and is shown on result for the single cycle that done is high; the receiver cannot
// stall it. Write scale_bits and use_pre only while no items are in flight.
module bf16_residual_add_scale import brsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]          cfg_data
);

	localparam int unsigned STG = 3;

	logic [31:0] scale_q;
	logic        use_pre_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= F32_ONE;
			use_pre_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				CFG_SCALE:   scale_q   <= cfg_data;
				CFG_USE_PRE: use_pre_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic        s_vld, t_vld, r_vld;
	logic [31:0] s_f32, t_f32, r_f32, x_f32;
	logic [15:0] pre_q [STG];
	logic [31:0] s_q   [STG];
	logic        last_q [3*STG];

	brsc_fadd u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start && !busy),
		.op_a   (bf16_widen(item.a_val)),
		.op_b   (bf16_widen(item.b_val)),
		.out_vld(s_vld),
		.sum    (s_f32)
	);

	always_ff @(posedge clk) begin
		pre_q[0]  <= item.pre_val;
		s_q[0]    <= s_f32;
		last_q[0] <= item.last_in;
		for (int i = 1; i < STG; i++) begin
			pre_q[i] <= pre_q[i-1];
			s_q[i]   <= s_q[i-1];
		end
		for (int i = 1; i < 3*STG; i++)
			last_q[i] <= last_q[i-1];
	end

	brsc_fadd u_pre (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (s_vld),
		.op_a   (bf16_widen(pre_q[STG-1])),
		.op_b   (bf16_widen(bf16_round(s_f32))),
		.out_vld(t_vld),
		.sum    (t_f32)
	);

	assign x_f32 = use_pre_q ? t_f32 : s_q[STG-1];

	brsc_fmul u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (t_vld),
		.op_a   (x_f32),
		.op_b   (scale_q),
		.out_vld(r_vld),
		.prod   (r_f32)
	);

	assign done              = r_vld;
	assign result.result_val = bf16_round(r_f32);
	assign result.last_out   = last_q[3*STG-1];

endmodule

// File: sim/brsc_checker.sv
// Checker: watches the residual kernel's channels, predicts each result and compares it.
module brsc_checker import brsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  item_t                item,
	input  logic                 done,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]          cfg_data,
	output int                   errors,
	output int                   pending
);

	localparam logic [31:0] SNGL_NAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [31:0] SNGL_QUIET_BIT   = 32'h0040_0000;

	logic [31:0] scale_reg;
	logic        pre_en;
	result_t     expected_q[$];

	function automatic logic sngl_nan(input logic [31:0] u);
		return (u[30:23] == 8'hFF) && (u[22:0] != 23'b0);
	endfunction

	function automatic logic sngl_inf(input logic [31:0] u);
		return (u[30:23] == 8'hFF) && (u[22:0] == 23'b0);
	endfunction

	function automatic real sngl_to_real(input logic [31:0] u);
		real r;
		if (u[30:0] == 31'b0)
			return $bitstoreal({u[31], 63'b0});
		if (u[30:23] == 8'h00) begin
			r = real'(u[22:0]) * $bitstoreal({1'b0, 11'd874, 52'b0});
			return u[31] ? -r : r;
		end
		if (u[30:23] == 8'hFF)
			return $bitstoreal({u[31], 11'h7FF, u[22:0], 29'b0});
		return $bitstoreal({u[31], 11'(int'(u[30:23]) - 127 + 1023), u[22:0], 29'b0});
	endfunction

	// round a double to single, nearest even, subnormals kept
	function automatic logic [31:0] real_to_sngl(input real r);
		logic [63:0]  d;
		logic         s;
		int           e;
		int           sh;
		logic [115:0] w;
		logic [23:0]  m;
		logic         g, st, inc;
		logic [24:0]  mr;
		logic [32:0]  v;
		d = $realtobits(r);
		s = d[63];
		if (d[62:52] == 11'h7FF)
			return {s, 8'hFF, 23'b0};
		if (d[62:0] == 63'b0)
			return {s, 31'b0};
		e = int'(d[62:52]) - 1023 + 127;
		if (e >= 255)
			return {s, 8'hFF, 23'b0};
		sh = (e >= 1) ? 0 : 1 - e;
		if (sh > 60)
			sh = 60;
		w   = {1'b1, d[51:0], 63'b0} >> sh;
		m   = w[115:92];
		g   = w[91];
		st  = |w[90:0];
		inc = g & (st | m[0]);
		mr  = {1'b0, m} + {24'b0, inc};
		v   = (e >= 1) ? (33'(e - 1) << 23) : 33'd0;
		v   = v + {8'b0, mr};
		if (v >= (33'd255 << 23))
			return {s, 8'hFF, 23'b0};
		return {s, v[30:0]};
	endfunction

	function automatic logic [31:0] sngl_add(input logic [31:0] x, input logic [31:0] y);
		if (sngl_nan(x))
			return x | SNGL_QUIET_BIT;
		if (sngl_nan(y))
			return y | SNGL_QUIET_BIT;
		if (sngl_inf(x) && sngl_inf(y) && (x[31] != y[31]))
			return SNGL_NAN_DEFAULT;
		return real_to_sngl(sngl_to_real(x) + sngl_to_real(y));
	endfunction

	function automatic logic [31:0] sngl_mul(input logic [31:0] x, input logic [31:0] y);
		if (sngl_nan(x))
			return x | SNGL_QUIET_BIT;
		if (sngl_nan(y))
			return y | SNGL_QUIET_BIT;
		if ((sngl_inf(x) && y[30:0] == 31'b0) || (sngl_inf(y) && x[30:0] == 31'b0))
			return SNGL_NAN_DEFAULT;
		return real_to_sngl(sngl_to_real(x) * sngl_to_real(y));
	endfunction

	function automatic logic [15:0] to_bf16(input logic [31:0] u);
		logic [31:0] r;
		if (sngl_nan(u))
			return u[31:16] | 16'h0040;
		r = u + 32'h0000_7FFF + {31'b0, u[16]};
		return r[31:16];
	endfunction

	function automatic result_t scaled_residual(input item_t it);
		logic [31:0] sum;
		logic [31:0] t;
		result_t     res;
		sum = sngl_add({it.a_val, 16'h0}, {it.b_val, 16'h0});
		if (pre_en)
			t = sngl_add({it.pre_val, 16'h0}, {to_bf16(sum), 16'h0});
		else
			t = sum;
		res.result_val = to_bf16(sngl_mul(t, scale_reg));
		res.last_out   = it.last_in;
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			scale_reg = F32_ONE;
			pre_en    = 1'b0;
			errors    = 0;
			expected_q.delete();
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, result);
				end else begin
					want = expected_q.pop_front();
					if (want.result_val !== result.result_val) begin
						errors++;
						$display("%0t: result_val expected %h actual %h", $time,
							want.result_val, result.result_val);
					end
					if (want.last_out !== result.last_out) begin
						errors++;
						$display("%0t: last_out expected %b actual %b", $time,
							want.last_out, result.last_out);
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(scaled_residual(item));
			if (cfg_valid && cfg_ready) begin
				if (cfg_addr == CFG_SCALE)
					scale_reg = cfg_data;
				else if (cfg_addr == CFG_USE_PRE)
					pre_en = cfg_data[0];
			end
		end
	end

endmodule

// File: sim/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the bf16 residual kernel.
module tb;
	import brsc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hA5;
	localparam int CYCLE_LIMIT = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	item_t                item;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [31:0]          cfg_data;
	int                   errors;
	int                   pending;
	int                   cycles;

	bf16_residual_add_scale dut (.*);

	brsc_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [15:0] pick_bf16(input logic [15:0] near);
		logic [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(0, 11))
			0: v = {v[15], 15'h0000};
			1: v = {v[15], 15'h7F80};
			2: v = {v[15], 8'hFF, v[6:0] | 7'h01};
			3: v = {v[15], 8'h00, v[6:0]};
			4: v = {v[15], 15'h7F7F};
			5: v = {~near[15], near[14:0]};
			6: v = {v[15], near[14:7], v[6:0]};
			7: v = {~near[15], near[14:7], v[6:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] addr, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_beat(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] p, input logic l);
		start <= 1'b1;
		item  <= '{a_val: a, b_val: b, pre_val: p, last_in: l};
		do @(posedge clk); while (busy);
	endtask

	task automatic drain;
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic directed_beats;
		logic [15:0] vals[12];
		vals = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'h7F81,
			16'hFFFF, 16'h7F7F, 16'h0001, 16'h0080, 16'h3F80, 16'hBF80};
		for (int i = 0; i < 12; i++)
			send_beat(vals[i], vals[(i * 5 + 3) % 12], vals[(i * 7 + 1) % 12], i[0]);
		send_beat(16'h7F80, 16'hFF80, 16'h3F80, 1'b1);
		send_beat(16'h7F7F, 16'h7F7F, 16'h0000, 1'b0);
		send_beat(16'h3F80, 16'hBF80, 16'h8000, 1'b1);
		send_beat(16'h3F81, 16'h3B80, 16'hBF80, 1'b0);
		send_beat(16'h0001, 16'h8001, 16'h0001, 1'b1);
		send_beat(16'h8000, 16'h8000, 16'h8000, 1'b0);
		start <= 1'b0;
	endtask

	task automatic random_beats(input int n);
		int          sent;
		int          burst;
		logic [15:0] a, b;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < n; k++) begin
				a = pick_bf16(16'($urandom));
				b = pick_bf16(a);
				send_beat(a, b, pick_bf16(a), 1'($urandom));
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		start <= 1'b0;
	endtask

	initial begin
		logic [31:0] scales[10];
		scales = '{32'h3F80_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'h0000_0001,
			32'h7F80_0000, 32'hFF80_0001, 32'hFFFF_FFFF, 32'hBE80_0000, 32'h4B00_0000,
			32'h8080_0000};
		arst_n    = 1'b0;
		cycles    = 0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_addr  = CFG_SCALE;
		cfg_data  = 32'h0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_beats();
		drain();
		cfg_write(CFG_USE_PRE, 32'h0000_0001);
		directed_beats();
		drain();
		for (int ph = 0; ph < 10; ph++) begin
			cfg_write(CFG_SCALE, scales[ph]);
			cfg_write(CFG_USE_PRE, ph[0] ? 32'hFFFF_FFFE : 32'h0000_0001);
			if (ph == 4)
				cfg_write(CFG_UNUSED, 32'h0000_0000);
			random_beats(135);
			drain();
		end
		cfg_write(CFG_SCALE, {1'b0, 8'($urandom_range(100, 150)), 23'($urandom)});
		cfg_write(CFG_USE_PRE, 32'h0000_0001);
		random_beats(260);
		drain();
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/brsc_pkg.sv
rtl/core/brsc_fadd.sv
rtl/core/brsc_fmul.sv
rtl/core/bf16_residual_add_scale.sv
sim/brsc_checker.sv
sim/tb.sv
